>>> sv/arpc_pkg.sv
package arpc_pkg;

  // operation codes
  localparam logic FUNC_STORE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // stamp that no valid entry can exceed
  localparam logic [31:0] STAMP_MAX = 32'hffff_ffff;

  // one request
  typedef struct packed {
    logic        func;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
    logic [31:0] now_tick;
  } req_t;

  // one result
  typedef struct packed {
    logic        hit;
    logic [47:0] mac_out;
    logic [2:0]  slot_index;
  } res_t;

  // one table entry as held in the RAM
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // flags from the compare unit
  typedef struct packed {
    logic ip_eq;
    logic older;
  } cmp_flags_t;

endpackage

>>> sv/arpc_ram.sv
module arpc_ram #(
  parameter int unsigned WIDTH = 112,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/arpc_cmp.sv
module arpc_cmp (
  input  arpc_pkg::entry_t     entry_i,
  input  logic [31:0]          key_ip_i,
  input  logic [31:0]          best_i,
  output arpc_pkg::cmp_flags_t flags_o
);

  // address match and age compare for the entry under scan
  always_comb begin
    flags_o.ip_eq = (entry_i.ip == key_ip_i);
    flags_o.older = (entry_i.stamp < best_i);
  end

endmodule

>>> sv/arp_cache_store_lookup_core.sv
// Channel   Ports                    Direction  Handshake
// request   start, req_i             in         taken when start && !busy
// result    done_o, res_o            out        valid for one cycle on done_o
//
// A request scans the table one entry per cycle through the RAM read port;
// the result strobe is registered from the decision, and a new request can
// be taken in the cycle the strobe shows.
// busy is high from the accept edge until the scan has finished.
// Reset clears all valid flags at once; the RAM contents need no clearing.
// The result side cannot stall: each result shows for exactly one cycle.
module arp_cache_store_lookup_core #(
  parameter int unsigned ENTRIES = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  arpc_pkg::req_t  req_i,
  output logic            busy,
  output logic            done_o,
  output arpc_pkg::res_t  res_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                 state_q, state_d;
  arpc_pkg::req_t       req_q;
  logic [CW-1:0]        rd_q, rd_d;
  logic [IW-1:0]        cmp_q, cmp_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [31:0]          best_q, best_d;
  logic [IW-1:0]        chosen_q, chosen_d;
  logic                 valid_q [ENTRIES];
  logic                 done_q, done_d;
  arpc_pkg::res_t       res_q, res_d;

  logic                 accept;
  logic                 finish;
  logic                 wr_en;
  logic [IW-1:0]        wr_slot;
  logic                 ev_valid;
  logic                 ev_match;
  logic [arpc_pkg::ENTRY_W-1:0] rdata;
  arpc_pkg::entry_t     rd_entry;
  arpc_pkg::entry_t     wr_entry;
  arpc_pkg::cmp_flags_t flags;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // entry storage
  assign wr_entry = '{ip: req_q.ip_addr, mac: req_q.mac_addr, stamp: req_q.now_tick};

  arpc_ram #(
    .WIDTH(arpc_pkg::ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_slot),
    .wdata_i(wr_entry),
    .raddr_i(rd_q[IW-1:0]),
    .rdata_o(rdata)
  );

  assign rd_entry = arpc_pkg::entry_t'(rdata);

  // shared compare unit
  arpc_cmp u_cmp (
    .entry_i (rd_entry),
    .key_ip_i(req_q.ip_addr),
    .best_i  (best_q),
    .flags_o (flags)
  );

  assign ev_valid = valid_q[cmp_q];
  assign ev_match = ev_valid && flags.ip_eq;

  // scan sequencer and decision
  always_comb begin
    state_d   = state_q;
    rd_d      = rd_q;
    cmp_d     = cmp_q;
    cmp_vld_d = cmp_vld_q;
    best_d    = best_q;
    chosen_d  = chosen_q;
    done_d    = 1'b0;
    res_d     = res_q;
    finish    = 1'b0;
    wr_en     = 1'b0;
    wr_slot   = cmp_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d   = ST_SCAN;
          rd_d      = '0;
          cmp_vld_d = 1'b0;
          best_d    = arpc_pkg::STAMP_MAX;
          chosen_d  = '0;
        end
      end
      ST_SCAN: begin
        // issue the next read while the previous entry is compared
        cmp_vld_d = (rd_q < CW'(ENTRIES));
        cmp_d     = rd_q[IW-1:0];
        if (rd_q < CW'(ENTRIES)) begin
          rd_d = rd_q + CW'(1);
        end
        if (cmp_vld_q) begin
          if (req_q.func == arpc_pkg::FUNC_LOOKUP) begin
            if (ev_match) begin
              finish = 1'b1;
              res_d  = '{hit: 1'b1, mac_out: rd_entry.mac, slot_index: 3'(cmp_q)};
            end else if (cmp_q == LAST) begin
              finish = 1'b1;
              res_d  = '{hit: 1'b0, mac_out: '0, slot_index: '0};
            end
          end else begin
            if (!ev_valid || ev_match) begin
              finish  = 1'b1;
              wr_slot = cmp_q;
            end else begin
              // oldest valid entry so far, first one on ties
              if (flags.older) begin
                best_d   = rd_entry.stamp;
                chosen_d = cmp_q;
              end
              if (cmp_q == LAST) begin
                finish  = 1'b1;
                wr_slot = chosen_d;
              end
            end
            wr_en = finish;
            res_d = '{hit: 1'b1, mac_out: '0, slot_index: 3'(wr_slot)};
          end
        end
        if (finish) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_q      <= '0;
      cmp_q     <= '0;
      cmp_vld_q <= 1'b0;
      done_q    <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      state_q   <= state_d;
      rd_q      <= rd_d;
      cmp_q     <= cmp_d;
      cmp_vld_q <= cmp_vld_d;
      done_q    <= done_d;
      if (wr_en) begin
        valid_q[wr_slot] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    best_q   <= best_d;
    chosen_q <= chosen_d;
    res_q    <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> sv/arpc_checker.sv
module arpc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input arpc_pkg::req_t req_i,
  input logic           busy,
  input logic           done_o,
  input arpc_pkg::res_t res_o
);

  // an accepted request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after accepting a request");

  // a result only shows once the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // the strobe lasts a single cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // no result can follow an accept in the very next cycle
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !done_o)
    else $error("result one cycle after accept");

  // a miss carries no MAC and slot zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.hit |-> (res_o.mac_out == '0) && (res_o.slot_index == '0))
    else $error("miss result with non-zero fields");

endmodule

bind arp_cache_store_lookup_core arpc_checker u_arpc_checker (.*);
